// ----- src/mvl1_pkg.sv -----
// ----------------------------------------------------------------------------
// mvl1_pkg
// Shared types, constants and the CRC-16/MCRF4XX byte update for the
// MAVLink v1 frame builder.
// ----------------------------------------------------------------------------
package mvl1_pkg;

  // Frame start marker and CRC seed
  localparam logic [7:0]  STX_BYTE = 8'hFE;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Configuration register indexes
  localparam logic [1:0] REG_OUTPUT_ENABLE = 2'd0;
  localparam logic [1:0] REG_SYSTEM_ID     = 2'd1;
  localparam logic [1:0] REG_COMPONENT_ID  = 2'd2;

  // Item kinds
  localparam logic KIND_START   = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  // Input item
  typedef struct packed {
    logic       kind;
    logic [7:0] message_id;
    logic [7:0] crc_extra;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
  } out_item_t;

  // Configuration register contents
  typedef struct packed {
    logic       output_enable;
    logic [7:0] system_id;
    logic [7:0] component_id;
  } cfg_t;

  // Bytes produced by one item; element 0 goes out first
  typedef struct packed {
    logic            valid;      // at least one byte
    logic [2:0]      last;       // index of the final byte
    logic            frame_end;  // burst closes a frame
    logic [7:0][7:0] bytes;
  } burst_t;

  // Frame state visible to the top level
  typedef struct packed {
    logic       frame_open;
    logic [7:0] bytes_remaining;
  } engine_status_t;

  // One byte of CRC-16/MCRF4XX (reflected 0x1021)
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  t;
    logic [15:0] tw;
    t  = b ^ crc[7:0];
    t  = t ^ {t[3:0], 4'b0000};
    tw = {8'h00, t};
    return {8'h00, crc[15:8]} ^ (tw << 8) ^ (tw << 3) ^ (tw >> 4);
  endfunction

endpackage

// ----- src/mvl1_frame_engine.sv -----
// ----------------------------------------------------------------------------
// mvl1_frame_engine
// Holds the frame state (sequence, running CRC, byte count, CRC extra) and
// turns one input item into its burst of output bytes in a single pass.
// ----------------------------------------------------------------------------
module mvl1_frame_engine (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mvl1_pkg::cfg_t          cfg,
  input  mvl1_pkg::in_item_t      item,
  input  logic                    step,
  output mvl1_pkg::burst_t        burst,
  output mvl1_pkg::engine_status_t status
);

  logic [7:0]  seq_r, seq_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  extra_r, extra_nxt;
  logic        open_r, open_nxt;

  // Header CRC chain, bytes after the start marker
  logic [15:0] c_len, c_seq, c_sys, c_comp, c_msg, c_hdr_fin;
  assign c_len     = mvl1_pkg::crc_byte(mvl1_pkg::CRC_INIT, item.payload_length);
  assign c_seq     = mvl1_pkg::crc_byte(c_len, seq_r);
  assign c_sys     = mvl1_pkg::crc_byte(c_seq, cfg.system_id);
  assign c_comp    = mvl1_pkg::crc_byte(c_sys, cfg.component_id);
  assign c_msg     = mvl1_pkg::crc_byte(c_comp, item.message_id);
  assign c_hdr_fin = mvl1_pkg::crc_byte(c_msg, item.crc_extra);

  // Payload byte CRC and its fold with the held extra byte
  logic [15:0] c_pay, c_pay_fin;
  logic [7:0]  rem_dec;
  assign c_pay     = mvl1_pkg::crc_byte(crc_r, item.data_byte);
  assign c_pay_fin = mvl1_pkg::crc_byte(c_pay, extra_r);
  assign rem_dec   = rem_r - 8'd1;

  // Burst and next state
  always_comb begin
    burst     = '0;
    seq_nxt   = seq_r;
    crc_nxt   = crc_r;
    rem_nxt   = rem_r;
    extra_nxt = extra_r;
    open_nxt  = open_r;
    if (item.kind == mvl1_pkg::KIND_START) begin
      if (cfg.output_enable) begin
        burst.valid    = 1'b1;
        burst.bytes[0] = mvl1_pkg::STX_BYTE;
        burst.bytes[1] = item.payload_length;
        burst.bytes[2] = seq_r;
        burst.bytes[3] = cfg.system_id;
        burst.bytes[4] = cfg.component_id;
        burst.bytes[5] = item.message_id;
        seq_nxt        = seq_r + 8'd1;
        extra_nxt      = item.crc_extra;
        rem_nxt        = item.payload_length;
        if (item.payload_length == 8'd0) begin
          // empty payload: CRC follows the header at once
          burst.bytes[6]  = c_hdr_fin[7:0];
          burst.bytes[7]  = c_hdr_fin[15:8];
          burst.last      = 3'd7;
          burst.frame_end = 1'b1;
          crc_nxt         = c_hdr_fin;
          open_nxt        = 1'b0;
        end else begin
          burst.last = 3'd5;
          crc_nxt    = c_msg;
          open_nxt   = 1'b1;
        end
      end else begin
        // disabled start closes any open frame
        open_nxt = 1'b0;
        rem_nxt  = 8'd0;
      end
    end else if (open_r) begin
      burst.valid    = 1'b1;
      burst.bytes[0] = item.data_byte;
      rem_nxt        = rem_dec;
      if (rem_dec == 8'd0) begin
        burst.bytes[1]  = c_pay_fin[7:0];
        burst.bytes[2]  = c_pay_fin[15:8];
        burst.last      = 3'd2;
        burst.frame_end = 1'b1;
        crc_nxt         = c_pay_fin;
        open_nxt        = 1'b0;
      end else begin
        crc_nxt = c_pay;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= 8'd0;
      crc_r   <= mvl1_pkg::CRC_INIT;
      rem_r   <= 8'd0;
      extra_r <= 8'd0;
      open_r  <= 1'b0;
    end else if (step) begin
      seq_r   <= seq_nxt;
      crc_r   <= crc_nxt;
      rem_r   <= rem_nxt;
      extra_r <= extra_nxt;
      open_r  <= open_nxt;
    end
  end

  assign status.frame_open      = open_r;
  assign status.bytes_remaining = rem_r;

endmodule

// ----- src/mvl1_byte_serializer.sv -----
// ----------------------------------------------------------------------------
// mvl1_byte_serializer
// Result register: holds one burst and shifts it out a byte per transfer.
// ----------------------------------------------------------------------------
module mvl1_byte_serializer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  mvl1_pkg::burst_t     burst,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mvl1_pkg::out_item_t  out_payload
);

  logic [7:0][7:0] bytes_r;
  logic [2:0]      left_r;
  logic            end_r;
  logic            busy_r;

  logic last_byte;
  assign last_byte = (left_r == 3'd0);

  // Free now, or freed by the final transfer of this cycle
  assign can_load = !busy_r || (out_ready && last_byte);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= 3'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      left_r <= burst.last;
    end else if (busy_r && out_ready) begin
      if (last_byte) begin
        busy_r <= 1'b0;
      end else begin
        left_r <= left_r - 3'd1;
      end
    end
  end

  // Byte line
  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r <= burst.bytes;
      end_r   <= burst.frame_end;
    end else if (busy_r && out_ready) begin
      bytes_r <= bytes_r >> 8;
    end
  end

  assign out_valid             = busy_r;
  assign out_payload.out_byte  = bytes_r[0];
  assign out_payload.frame_end = end_r && last_byte;
  assign out_payload.run_last  = last_byte;

endmodule

// ----- src/mavlink_v1_frame_builder_top.sv -----
// ----------------------------------------------------------------------------
// mavlink_v1_frame_builder_top
// MAVLink v1 frame builder: header, payload pass-through and CRC-16/MCRF4XX.
//
//   channel  direction  signals
//   in_      input      in_valid, in_ready, in_payload (in_item_t)
//   out_     output     out_valid, out_ready, out_payload (out_item_t)
//   cfg_     input      cfg_valid, cfg_ready, cfg_index[1:0], cfg_data[7:0]
//
// An item waits in the input register, where its whole burst
// (0 to 8 bytes) is formed, then its bytes leave the output register one
// per transfer. Throughput is set by the output byte line; an item giving
// no bytes leaves the input register without loading it. The next burst
// is formed while the previous one drains. Synchronous active-low reset, no clearing pass.
// A stalled output holds the burst while one more item waits at the input.
// ----------------------------------------------------------------------------
module mavlink_v1_frame_builder_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mvl1_pkg::in_item_t  in_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output mvl1_pkg::out_item_t out_payload,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  mvl1_pkg::cfg_t             cfg_r;
  mvl1_pkg::in_item_t         item_r;
  logic                       full_r;
  mvl1_pkg::burst_t           burst;
  mvl1_pkg::engine_status_t   status;
  logic                       ser_can_load;
  logic                       advance;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.output_enable <= 1'b1;
      cfg_r.system_id     <= 8'd1;
      cfg_r.component_id  <= 8'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mvl1_pkg::REG_OUTPUT_ENABLE: cfg_r.output_enable <= cfg_data[0];
        mvl1_pkg::REG_SYSTEM_ID:     cfg_r.system_id     <= cfg_data;
        mvl1_pkg::REG_COMPONENT_ID:  cfg_r.component_id  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register; item leaves once its burst fits the output side
  assign advance  = full_r && (!burst.valid || ser_can_load);
  assign in_ready = !full_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      full_r <= 1'b1;
    end else if (advance) begin
      full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_payload;
    end
  end

  mvl1_frame_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .item   (item_r),
    .step   (advance),
    .burst  (burst),
    .status (status)
  );

  mvl1_byte_serializer u_serializer (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (advance && burst.valid),
    .burst       (burst),
    .can_load    (ser_can_load),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_payload (out_payload)
  );

`ifndef SYNTHESIS
  // Frame end only on the last byte of a burst
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.frame_end |-> out_payload.run_last)
    else $error("frame_end on a byte that is not last of its burst");

  // A waiting item is held until it moves on
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    full_r && !advance |=> full_r && $stable(item_r))
    else $error("input register lost a waiting item");

  // An open frame always has bytes still to come
  a_open_count: assert property (@(posedge clk) disable iff (!rst_n)
    status.frame_open |-> status.bytes_remaining != 8'd0)
    else $error("frame open with zero bytes remaining");
`endif

endmodule
